FILE: design/ctp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctp_pkg
// Shared constants, types and helpers for the columnar transposition block.
// ----------------------------------------------------------------------------
package ctp_pkg;

  localparam int MAX_LEN_DEF     = 64;
  localparam int MAX_COLUMNS_DEF = 8;

  localparam int DATA_W     = 8;
  localparam int COLS_W     = 4;
  localparam int ORDER_W    = 24;
  localparam int KEY_W      = 3;
  localparam int KIDX_W     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_MODE         = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_ORDER = 2'd2;

  localparam logic               MODE_RESET         = 1'b0;
  localparam logic [COLS_W-1:0]  COLUMN_COUNT_RESET = 4'd5;
  localparam logic [ORDER_W-1:0] COLUMN_ORDER_RESET = 24'd16434824;

  localparam logic [COLS_W-1:0]  MIN_COLUMNS = 4'd2;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  typedef struct packed {
    logic load_en;
    logic scan_start;
    logic scan_run;
    logic scan_fill;
    logic out_start;
    logic out_run;
    logic flush;
    logic run_end;
    logic clear_filled;
  } cmd_t;

  typedef struct packed {
    logic eom_fire;
    logic mode;
    logic scan_done;
    logic out_done;
    logic pipe_empty;
  } status_t;

  typedef struct packed {
    logic [DATA_W-1:0] out_byte;
    logic              last;
    logic              overflow;
  } res_t;

  // column index held at key position idx
  function automatic logic [KEY_W-1:0] column_at(input logic [ORDER_W-1:0] order,
                                                 input logic [KEY_W-1:0] idx);
    logic [4:0] sh;
    sh = 5'(idx) * 5'd3;
    return order[sh +: KEY_W];
  endfunction

endpackage

FILE: design/ctp_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctp_in_if
// Message byte channel: valid/ready with data byte and end-of-message flag.
// ----------------------------------------------------------------------------
interface ctp_in_if;
  logic                          valid;
  logic                          ready;
  logic [ctp_pkg::DATA_W-1:0]    data_byte;
  logic                          end_of_message;

  modport source (output valid, output data_byte, output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

FILE: design/ctp_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctp_out_if
// Result byte channel: valid/ready with byte, last and overflow flags.
// ----------------------------------------------------------------------------
interface ctp_out_if;
  logic                          valid;
  logic                          ready;
  logic [ctp_pkg::DATA_W-1:0]    out_byte;
  logic                          last;
  logic                          overflow;

  modport source (output valid, output out_byte, output last, output overflow, input ready);
  modport sink   (input valid, input out_byte, input last, input overflow, output ready);
endinterface

FILE: design/ctp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctp_ctrl
// Phase sequencer: load, encrypt scan, decrypt fill, decrypt read-out, flush.
// ----------------------------------------------------------------------------
module ctp_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  ctp_pkg::status_t status,
  output ctp_pkg::cmd_t    cmd
);

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_ENC   = 3'd1;
  localparam logic [2:0] S_DFILL = 3'd2;
  localparam logic [2:0] S_DOUT  = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_LOAD: begin
        cmd.load_en = 1'b1;
        if (status.eom_fire) begin
          cmd.scan_start   = 1'b1;
          cmd.clear_filled = 1'b1;
          state_next       = status.mode ? S_DFILL : S_ENC;
        end
      end
      S_ENC: begin
        cmd.scan_run = 1'b1;
        if (status.scan_done) begin
          state_next = S_FLUSH;
        end
      end
      S_DFILL: begin
        cmd.scan_run  = 1'b1;
        cmd.scan_fill = 1'b1;
        if (status.scan_done) begin
          cmd.out_start = 1'b1;
          state_next    = S_DOUT;
        end
      end
      S_DOUT: begin
        cmd.out_run = 1'b1;
        if (status.out_done) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        // wait for reads in flight, then release the held byte as the last one
        if (status.pipe_empty) begin
          cmd.flush   = 1'b1;
          cmd.run_end = 1'b1;
          state_next  = S_LOAD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

endmodule

FILE: design/ctp_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctp_datapath
// Configuration registers, message buffer, decrypt grid, key-order address
// walker and the one-byte hold stage that settles the last flag.
// ----------------------------------------------------------------------------
module ctp_datapath #(
  parameter int MAX_LEN     = ctp_pkg::MAX_LEN_DEF,
  parameter int MAX_COLUMNS = ctp_pkg::MAX_COLUMNS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [ctp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ctp_pkg::CFG_DATA_W-1:0]    cfg_data,
  ctp_in_if.sink                            message,
  input  ctp_pkg::cmd_t                     cmd,
  output ctp_pkg::status_t                  status,
  input  logic [ctp_pkg::FIFO_AW:0]         fifo_count,
  output logic                              push,
  output ctp_pkg::res_t                     push_data
);

  localparam int AW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int PW = $clog2(MAX_LEN + MAX_COLUMNS);
  localparam int OW = ctp_pkg::FIFO_AW + 2;

  // configuration
  logic                               mode;
  logic [ctp_pkg::COLS_W-1:0]         column_count;
  logic [ctp_pkg::ORDER_W-1:0]        column_order;
  logic [ctp_pkg::COLS_W-1:0]         cols;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= ctp_pkg::MODE_RESET;
      column_count <= ctp_pkg::COLUMN_COUNT_RESET;
      column_order <= ctp_pkg::COLUMN_ORDER_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ctp_pkg::REG_MODE:         mode         <= cfg_data[0];
        ctp_pkg::REG_COLUMN_COUNT: column_count <= cfg_data[ctp_pkg::COLS_W-1:0];
        ctp_pkg::REG_COLUMN_ORDER: column_order <= cfg_data[ctp_pkg::ORDER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (column_count < ctp_pkg::MIN_COLUMNS) begin
      cols = ctp_pkg::MIN_COLUMNS;
    end else if (column_count > ctp_pkg::COLS_W'(MAX_COLUMNS)) begin
      cols = ctp_pkg::COLS_W'(MAX_COLUMNS);
    end else begin
      cols = column_count;
    end
  end

  // message loading
  logic                      in_fire;
  logic                      full;
  logic [CW-1:0]             byte_count;
  logic                      overflow_seen;

  assign message.ready = cmd.load_en;
  assign in_fire       = message.valid && message.ready;
  assign full          = (byte_count == CW'(MAX_LEN));

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= '0;
      overflow_seen <= 1'b0;
    end else if (cmd.run_end) begin
      byte_count    <= '0;
      overflow_seen <= 1'b0;
    end else if (in_fire) begin
      if (full) begin
        overflow_seen <= 1'b1;
      end else begin
        byte_count <= byte_count + 1'b1;
      end
    end
  end

  // key-order walker: one column position per cycle while it may step, stepping by the column count
  logic [ctp_pkg::KIDX_W-1:0]         key_idx;
  logic                               first;
  logic [PW-1:0]                      pos;
  logic [CW-1:0]                      made;
  logic [ctp_pkg::KEY_W-1:0]          key_col;
  logic [PW-1:0]                      cur;
  logic                               col_ok;
  logic                               hit;
  logic                               scan_done;
  logic                               scan_step;
  logic                               scan_issue;
  logic [OW-1:0]                      occupancy;
  logic                               room;

  logic                               s1_valid;
  logic                               s1_grid;
  logic                               fill_valid;
  logic                               pend_valid;

  assign key_col   = ctp_pkg::column_at(column_order, key_idx[ctp_pkg::KEY_W-1:0]);
  assign cur       = first ? PW'(key_col) : pos;
  assign col_ok    = ({1'b0, key_col} < cols);
  assign hit       = col_ok && (cur < PW'(byte_count));
  assign scan_done = (key_idx == cols) || (made == byte_count);

  // results already committed downstream must fit the output queue
  assign occupancy = OW'(fifo_count) + OW'(s1_valid) + OW'(pend_valid);
  assign room      = (occupancy < OW'(ctp_pkg::FIFO_DEPTH));

  assign scan_step  = cmd.scan_run && !scan_done && (cmd.scan_fill || room);
  assign scan_issue = scan_step && hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_idx <= '0;
      first   <= 1'b1;
      made    <= '0;
    end else if (cmd.scan_start) begin
      key_idx <= '0;
      first   <= 1'b1;
      made    <= '0;
    end else if (scan_step) begin
      if (hit) begin
        first <= 1'b0;
        made  <= made + 1'b1;
      end else begin
        key_idx <= key_idx + 1'b1;
        first   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scan_step && hit) begin
      pos <= cur + PW'(cols);
    end
  end

  // read-out of the decrypt grid in row order
  logic [CW-1:0] opos;
  logic          out_done;
  logic          out_step;

  assign out_done = (opos == byte_count);
  assign out_step = cmd.out_run && !out_done && room;

  always_ff @(posedge clk) begin
    if (rst) begin
      opos <= '0;
    end else if (cmd.out_start) begin
      opos <= '0;
    end else if (out_step) begin
      opos <= opos + 1'b1;
    end
  end

  // message buffer
  logic [ctp_pkg::DATA_W-1:0] store [MAX_LEN];
  logic [ctp_pkg::DATA_W-1:0] rd_store;
  logic [AW-1:0]              store_raddr;

  assign store_raddr = cmd.scan_fill ? made[AW-1:0] : cur[AW-1:0];

  always_ff @(posedge clk) begin
    if (in_fire && !full) begin
      store[byte_count[AW-1:0]] <= message.data_byte;
    end
    if (scan_issue) begin
      rd_store <= store[store_raddr];
    end
  end

  // decrypt grid
  logic [ctp_pkg::DATA_W-1:0] grid [MAX_LEN];
  logic [MAX_LEN-1:0]         filled;
  logic [ctp_pkg::DATA_W-1:0] rd_grid;
  logic                       rd_filled;
  logic [AW-1:0]              fill_q;

  always_ff @(posedge clk) begin
    if (fill_valid) begin
      grid[fill_q] <= rd_store;
    end
    if (out_step) begin
      rd_grid <= grid[opos[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= '0;
    end else if (cmd.clear_filled) begin
      filled <= '0;
    end else if (fill_valid) begin
      filled[fill_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_step) begin
      rd_filled <= filled[opos[AW-1:0]];
    end
    if (scan_issue) begin
      fill_q <= cur[AW-1:0];
    end
  end

  // read-data stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      s1_grid    <= 1'b0;
      fill_valid <= 1'b0;
    end else begin
      s1_valid   <= (scan_issue && !cmd.scan_fill) || out_step;
      s1_grid    <= out_step;
      fill_valid <= scan_issue && cmd.scan_fill;
    end
  end

  logic [ctp_pkg::DATA_W-1:0] s1_byte;
  assign s1_byte = s1_grid ? (rd_filled ? rd_grid : '0) : rd_store;

  // hold one byte back until it is known whether another follows
  logic [ctp_pkg::DATA_W-1:0] pend_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (s1_valid) begin
      pend_valid <= 1'b1;
    end else if (cmd.flush) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      pend_byte <= s1_byte;
    end
  end

  assign push               = pend_valid && (s1_valid || cmd.flush);
  assign push_data.out_byte = pend_byte;
  assign push_data.last     = cmd.flush;
  assign push_data.overflow = overflow_seen;

  assign status.eom_fire   = in_fire && message.end_of_message;
  assign status.mode       = mode;
  assign status.scan_done  = scan_done;
  assign status.out_done   = out_done;
  assign status.pipe_empty = !s1_valid && !fill_valid;

endmodule

FILE: design/ctp_out_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctp_out_fifo
// Small result queue that decouples the read pipeline from output stalls.
// ----------------------------------------------------------------------------
module ctp_out_fifo (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  ctp_pkg::res_t              push_data,
  output logic [ctp_pkg::FIFO_AW:0]  count,
  ctp_out_if.source                  result
);

  ctp_pkg::res_t                     entries [ctp_pkg::FIFO_DEPTH];
  logic [ctp_pkg::FIFO_AW-1:0]       wr_ptr;
  logic [ctp_pkg::FIFO_AW-1:0]       rd_ptr;
  logic                              pop;
  ctp_pkg::res_t                     head;

  assign pop          = result.valid && result.ready;
  assign result.valid = (count != '0);
  assign head         = entries[rd_ptr];
  assign result.out_byte = head.out_byte;
  assign result.last     = head.last;
  assign result.overflow = head.overflow;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: design/columnar_transposition_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// columnar_transposition_top
// Columnar transposition cipher: buffers a message, then emits it read out
// by columns in key order (encrypt) or refilled by columns and read by rows
// (decrypt).
//
//   channel   dir  handshake       payload
//   message   in   valid/ready     data_byte[7:0], end_of_message
//   result    out  valid/ready     out_byte[7:0], last, overflow
//   cfg       in   cfg_we only     cfg_index[1:0], cfg_data[23:0]
//
// bytes load at one per cycle; the end-of-message byte starts the run and
// message is held off until the run has been handed to the result queue
// encrypt run: at most one buffer read per cycle, and only while the result queue has room
// decrypt run: a fill phase, then a row-order read-out phase, both paced by
// the single read port of the message buffer and of the grid
// result stalls back-pressure the encrypt walker and the decrypt read-out through a four-entry result queue
// synchronous active-high reset; buffer contents need no clearing
// ----------------------------------------------------------------------------
module columnar_transposition_top #(
  parameter int MAX_LEN     = ctp_pkg::MAX_LEN_DEF,
  parameter int MAX_COLUMNS = ctp_pkg::MAX_COLUMNS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ctp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ctp_pkg::CFG_DATA_W-1:0]  cfg_data,
  ctp_in_if.sink                          message,
  ctp_out_if.source                       result
);

  ctp_pkg::cmd_t                  cmd;
  ctp_pkg::status_t               status;
  logic                           push;
  ctp_pkg::res_t                  push_data;
  logic [ctp_pkg::FIFO_AW:0]      fifo_count;

  ctp_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  ctp_datapath #(
    .MAX_LEN     (MAX_LEN),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .message    (message),
    .cmd        (cmd),
    .status     (status),
    .fifo_count (fifo_count),
    .push       (push),
    .push_data  (push_data)
  );

  ctp_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .count     (fifo_count),
    .result    (result)
  );

endmodule

FILE: sim/ctp_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctp_tb_pkg
// Codes shared by the transposition testbench and its checker.
// ----------------------------------------------------------------------------
package ctp_tb_pkg;

  localparam logic MODE_ENCRYPT = 1'b0;
  localparam logic MODE_DECRYPT = 1'b1;

endpackage

FILE: sim/transposition_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// transposition_checker
// Watches the message, result and register ports of the transposition block,
// rebuilds each transposed run when a message ends and compares every result
// transaction field by field against the oldest byte still owed.
// ----------------------------------------------------------------------------
module transposition_checker
  import ctp_pkg::*;
  import ctp_tb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  ctp_in_if                     msg_mon,
  ctp_out_if                    res_mon,
  input  logic                  end_check,
  output int                    fail_count,
  output int                    pending
);

  localparam int BUF_LEN    = MAX_LEN_DEF;
  localparam int MAX_COLS   = MAX_COLUMNS_DEF;
  localparam int REPORT_CAP = 40;

  logic               mode_q;
  logic [COLS_W-1:0]  cols_q;
  logic [ORDER_W-1:0] order_q;

  logic [DATA_W-1:0]  msg_buf [BUF_LEN];
  int                 held_count;
  logic               truncated;
  res_t               owed_bytes [$];
  bit                 end_done;

  task automatic report_mismatch(input string what);
    if (fail_count < REPORT_CAP) $display("[%0t] mismatch: %s", $time, what);
    fail_count++;
  endtask

  // rebuild the whole run for the message just closed
  task automatic transpose_message();
    res_t              run_out [BUF_LEN];
    logic [DATA_W-1:0] grid [BUF_LEN];
    bit                filled [BUF_LEN];
    int                n, cols, rows, rem, made, k, c, h, p;
    n    = held_count;
    cols = (cols_q < MIN_COLUMNS) ? int'(MIN_COLUMNS) :
           (cols_q > MAX_COLS) ? MAX_COLS : int'(cols_q);
    rows = (n + cols - 1) / cols;
    rem  = n % cols;
    made = 0;
    k    = 0;
    if (mode_q == MODE_ENCRYPT) begin
      // columns in key order, top to bottom; stops once n bytes are out
      for (int i = 0; i < cols; i++) begin
        c = int'(order_q[3*i +: KEY_W]);
        if (c < cols) begin
          for (int r = 0; r < rows; r++) begin
            p = r * cols + c;
            if (p < n && made < n) begin
              run_out[made] = {msg_buf[p], 1'b0, truncated};
              made++;
            end
          end
        end
      end
      if (made > 0) run_out[made-1].last = 1'b1;
    end else begin
      for (int q = 0; q < BUF_LEN; q++) begin
        grid[q]   = '0;
        filled[q] = 1'b0;
      end
      // fill columns in key order, short columns one cell shorter
      for (int i = 0; i < cols; i++) begin
        c = int'(order_q[3*i +: KEY_W]);
        if (c < cols) begin
          h = (rem == 0 || c < rem) ? rows : rows - 1;
          for (int r = 0; r < h; r++) begin
            p = r * cols + c;
            if (k < n && p < BUF_LEN) begin
              grid[p]   = msg_buf[k];
              filled[p] = 1'b1;
              k++;
            end
          end
        end
      end
      for (int q = 0; q < n; q++)
        run_out[q] = {(filled[q] ? grid[q] : 8'h00), (q == n - 1), truncated};
      made = n;
    end
    for (int j = 0; j < made; j++) owed_bytes.push_back(run_out[j]);
  endtask

  task automatic take_byte(input logic [DATA_W-1:0] b, input logic eom);
    if (held_count < BUF_LEN) begin
      msg_buf[held_count] = b;
      held_count++;
    end else begin
      truncated = 1'b1;
    end
    if (eom) begin
      transpose_message();
      held_count = 0;
      truncated  = 1'b0;
    end
  endtask

  task automatic check_result(input res_t got);
    res_t want;
    if (owed_bytes.size() == 0) begin
      report_mismatch($sformatf("result %02h with nothing owed", got.out_byte));
      return;
    end
    want = owed_bytes.pop_front();
    if (got.out_byte !== want.out_byte)
      report_mismatch($sformatf("out_byte %02h, want %02h", got.out_byte, want.out_byte));
    if (got.last !== want.last)
      report_mismatch($sformatf("last %b, want %b", got.last, want.last));
    if (got.overflow !== want.overflow)
      report_mismatch($sformatf("overflow %b, want %b", got.overflow, want.overflow));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      mode_q     = MODE_RESET;
      cols_q     = COLUMN_COUNT_RESET;
      order_q    = COLUMN_ORDER_RESET;
      held_count = 0;
      truncated  = 1'b0;
      owed_bytes.delete();
      fail_count = 0;
      end_done   = 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MODE:         mode_q  = cfg_data[0];
          REG_COLUMN_COUNT: cols_q  = cfg_data[COLS_W-1:0];
          REG_COLUMN_ORDER: order_q = cfg_data[ORDER_W-1:0];
          default: ;
        endcase
      end
      if (msg_mon.valid && msg_mon.ready)
        take_byte(msg_mon.data_byte, msg_mon.end_of_message);
      if (res_mon.valid && res_mon.ready)
        check_result({res_mon.out_byte, res_mon.last, res_mon.overflow});
      if (end_check && !end_done) begin
        end_done = 1'b1;
        if (owed_bytes.size() != 0)
          report_mismatch($sformatf("%0d results never arrived", owed_bytes.size()));
      end
    end
    pending = owed_bytes.size();
  end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the transposition block with directed corner messages and then with
// random messages under random keys and column counts, with random gaps on
// both channels, a no-gap stretch and one long result hold-off; the checker
// beside the block does the comparison and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import ctp_pkg::*;
  import ctp_tb_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_PAD   = 160;
  localparam int STALL_LIMIT = 3000;
  localparam int RUN_ITEMS   = 250;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  end_check;
  int                    fail_count;
  int                    pending;

  bit quiet;
  bit hold_req;
  int sent_bytes;

  ctp_in_if  msg_if ();
  ctp_out_if res_if ();

  columnar_transposition_top u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .message   (msg_if),
    .result    (res_if)
  );

  transposition_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .msg_mon    (msg_if),
    .res_mon    (res_if),
    .end_check  (end_check),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic set_config(input logic m, input logic [COLS_W-1:0] cols,
                            input logic [ORDER_W-1:0] key);
    cfg_we    <= 1'b1;
    cfg_index <= REG_MODE;
    cfg_data  <= CFG_DATA_W'(m);
    @(posedge clk);
    cfg_index <= REG_COLUMN_COUNT;
    cfg_data  <= CFG_DATA_W'(cols);
    @(posedge clk);
    cfg_index <= REG_COLUMN_ORDER;
    cfg_data  <= key;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic send_byte(input logic [DATA_W-1:0] b, input logic eom);
    while (!quiet && $urandom_range(0, 99) < 35) begin
      msg_if.valid <= 1'b0;
      @(posedge clk);
    end
    msg_if.valid          <= 1'b1;
    msg_if.data_byte      <= b;
    msg_if.end_of_message <= eom;
    @(posedge clk);
    while (!msg_if.ready) @(posedge clk);
    sent_bytes++;
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++)
      send_byte(DATA_W'($urandom_range(0, 255)), i == len - 1);
  endtask

  // wait for every owed result, then let a run with no results finish too
  task automatic let_drain();
    msg_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 16);
    if (r < 92) return $urandom_range(17, 64);
    return $urandom_range(65, 72);
  endfunction

  // proper key over the columns in use, junk in the unused positions
  function automatic logic [ORDER_W-1:0] shuffled_key(input int cols);
    int                 perm [MAX_COLUMNS_DEF];
    int                 j, t;
    logic [ORDER_W-1:0] key;
    for (int i = 0; i < MAX_COLUMNS_DEF; i++) perm[i] = i;
    for (int i = cols - 1; i > 0; i--) begin
      j       = $urandom_range(0, i);
      t       = perm[i];
      perm[i] = perm[j];
      perm[j] = t;
    end
    key = ORDER_W'($urandom);
    for (int i = 0; i < cols; i++) key[3*i +: KEY_W] = KEY_W'(perm[i]);
    return key;
  endfunction

  // result side: random stalls, one long hold-off on request
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        res_if.ready <= quiet || ($urandom_range(0, 99) >= 35);
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((msg_if.valid && msg_if.ready) || (res_if.valid && res_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    logic [DATA_W-1:0]  corner_bytes [7];
    logic               m;
    int                 cols_reg, eff_cols, r, phase;
    logic [ORDER_W-1:0] key;
    corner_bytes = '{8'h00, 8'hFF, 8'hA5, 8'h5A, 8'h01, 8'h80, 8'h7F};
    quiet      = 1'b0;
    hold_req   = 1'b0;
    sent_bytes = 0;
    rst                   <= 1'b1;
    cfg_we                <= 1'b0;
    cfg_index             <= REG_MODE;
    cfg_data              <= '0;
    msg_if.valid          <= 1'b0;
    msg_if.data_byte      <= '0;
    msg_if.end_of_message <= 1'b0;
    end_check             <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: encrypt, five columns
    for (int i = 0; i < 7; i++) send_byte(corner_bytes[i], i == 6);
    send_byte(8'hFF, 1'b1);
    let_drain();
    // column count above range, reversed key, one byte in the short row
    set_config(MODE_DECRYPT, 4'd15, 24'h053977);
    send_message(9);
    let_drain();
    // column count below range, key repeating column zero
    set_config(MODE_ENCRYPT, 4'd0, 24'h000000);
    send_message(5);
    let_drain();
    // every key entry out of range: empty run
    set_config(MODE_ENCRYPT, 4'd3, 24'hFFFFFF);
    send_message(2);
    let_drain();
    // repeated and skipped entries while decrypting leave a cell unfilled
    set_config(MODE_DECRYPT, 4'd4, 24'hFFF189);
    send_message(3);
    let_drain();

    phase = 0;
    while (sent_bytes < RUN_ITEMS) begin
      m        = logic'($urandom_range(0, 1));
      cols_reg = ($urandom_range(0, 99) < 85) ? $urandom_range(2, 8) : $urandom_range(0, 15);
      eff_cols = (cols_reg < 2) ? 2 : (cols_reg > MAX_COLUMNS_DEF) ? MAX_COLUMNS_DEF : cols_reg;
      r        = $urandom_range(0, 99);
      if (phase == 0 || r < 70) key = shuffled_key(eff_cols);
      else if (r < 78)          key = 24'h000000;
      else if (r < 85)          key = 24'hFFFFFF;
      else                      key = ORDER_W'($urandom);
      set_config(m, COLS_W'(cols_reg), key);
      if (phase == 0) begin
        // full buffer, then one byte too many carrying the end flag
        send_message(64);
        send_message(65);
      end else if (phase == 1) begin
        // result side holds off while messages keep coming
        hold_req = 1'b1;
        repeat (4) send_message(12);
      end else if (phase == 2) begin
        quiet = 1'b1;
        repeat (5) send_message($urandom_range(4, 16));
      end else begin
        repeat ($urandom_range(1, 4)) send_message(pick_length());
      end
      let_drain();
      quiet = 1'b0;
      phase++;
    end

    end_check <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: files.f
design/ctp_pkg.sv
design/ctp_in_if.sv
design/ctp_out_if.sv
design/ctp_ctrl.sv
design/ctp_datapath.sv
design/ctp_out_fifo.sv
design/columnar_transposition_top.sv
sim/ctp_tb_pkg.sv
sim/transposition_checker.sv
sim/tb_top.sv
